[hdl/isp_pkg.sv]
// isp_pkg: shared constants for the interpolating sample player.
// Holds default parameters, field widths, register indexes, kinds and play modes.
// No dependencies.
package isp_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W  = 16;
    localparam int CTL_W     = 32;
    localparam int MODE_W    = 3;
    localparam int LENGTH_W  = 17;
    localparam int REGION_W  = 16;
    localparam int RATIO_W   = 24;
    localparam int ISR_W     = 32;
    localparam int KIND_W    = 2;

    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_PLAY_MODE   = 3'd0;
    localparam logic [2:0] REG_LENGTH      = 3'd1;
    localparam logic [2:0] REG_START       = 3'd2;
    localparam logic [2:0] REG_END         = 3'd3;
    localparam logic [2:0] REG_RATE_RATIO  = 3'd4;
    localparam logic [2:0] REG_INV_SYSRATE = 3'd5;

    localparam logic [MODE_W-1:0]   MODE_RST    = 3'd0;
    localparam logic [LENGTH_W-1:0] LENGTH_RST  = 17'd65536;
    localparam logic [REGION_W-1:0] START_RST   = 16'd0;
    localparam logic [REGION_W-1:0] END_RST     = 16'd65535;
    localparam logic [RATIO_W-1:0]  RATIO_RST   = 24'd65536;
    localparam logic [ISR_W-1:0]    ISR_RST     = 32'd97391;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIGGER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    // play modes
    localparam logic [MODE_W-1:0] MODE_LOOP       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ONCE       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOP_SPEED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ONCE_SPEED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REGION_LIN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REGION_CUB = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7    = 3'd7;

endpackage

[hdl/interpolating_sample_player.sv]
// Interpolating sample player: one sampler voice. A write transfer (kind 0) stores a sample,
// a trigger transfer (kind 1) zeroes the play position, and a tick transfer (kind 2) moves the
// position and returns one interpolated sample, looped, played once or in a region per play_mode.
// Writes and triggers are done on acceptance. A tick runs the step product (speed and region
// modes; region modes add two scaling products), the position update, the neighbor fetch and
// the linear or Hermite products; play-once past the end goes straight to the output. Any
// wait for the result register to drain adds to a tick. The sequence is set by the one
// shared 33x33 multiplier, which does the step and all interpolation products in turn, and
// by the single read port of the sample memory, which fetches up to four neighbors one per
// cycle. The sample memory is not cleared: only entries that were written may be played.
// Depends on isp_pkg.
module interpolating_sample_player #(
    parameter int ADDR_BITS = isp_pkg::ADDR_BITS_DEF,
    parameter int FRAC_BITS = isp_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // address[15:0], sample_data[31:16], rate_control[63:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample_out[15:0]
    output logic [0:0]  m_tuser,   // past_end[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int A   = ADDR_BITS;
    localparam int F   = FRAC_BITS;
    localparam int MX  = (A > 16) ? A : 16;
    localparam int PW  = A + F + 2;
    localparam int SW  = MX + F + 18;
    localparam int IW  = A + 3;
    localparam int MW  = 33;
    localparam int PMW = 2 * MW;
    localparam int AW  = F + 26;
    localparam int KW  = 21;
    localparam logic [31:0] LEN_CAP = 32'd1 << A;
    localparam logic signed [SW-1:0] ONE_S   = SW'(1) <<< F;
    localparam logic signed [SW-1:0] POS_MAX = (SW'(1) <<< (A + F)) - SW'(1);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_INC  = 14'b00000000000010,
        S_LO   = 14'b00000000000100,
        S_HI   = 14'b00000000001000,
        S_POS  = 14'b00000000010000,
        S_IDX  = 14'b00000000100000,
        S_RD   = 14'b00000001000000,
        S_COEF = 14'b00000010000000,
        S_L1   = 14'b00000100000000,
        S_L2   = 14'b00001000000000,
        S_H1   = 14'b00010000000000,
        S_H2   = 14'b00100000000000,
        S_H3   = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } state_t;

    typedef enum logic [3:0] {
        IT_DIRECT = 4'b0001,
        IT_LERP   = 4'b0010,
        IT_HERM   = 4'b0100,
        IT_ZERO   = 4'b1000
    } interp_t;

    function automatic logic signed [SW-1:0] clamp_pos(input logic signed [SW-1:0] p);
        if (p > POS_MAX)
            return POS_MAX;
        else if (p < -POS_MAX)
            return -POS_MAX;
        else
            return p;
    endfunction

    function automatic logic [A-1:0] clamp_idx(input logic signed [IW-1:0] i,
                                               input logic signed [IW-1:0] top);
        if (i < 0)
            return '0;
        else if (i > top)
            return A'(top);
        else
            return A'(i);
    endfunction

    // configuration
    logic [isp_pkg::MODE_W-1:0]   mode_reg;
    logic [isp_pkg::LENGTH_W-1:0] length_reg;
    logic [isp_pkg::REGION_W-1:0] start_reg;
    logic [isp_pkg::REGION_W-1:0] end_reg;
    logic [isp_pkg::RATIO_W-1:0]  ratio_reg;
    logic [isp_pkg::ISR_W-1:0]    isr_reg;
    logic                         cfg_we;

    // control
    state_t               state_reg, state_next;
    interp_t              itype_reg;
    logic [2:0]           rd_cnt_reg;
    logic [2:0]           n_reg;
    logic                 out_valid_reg;
    logic signed [PW-1:0] pos_reg;
    logic                 past_reg;

    // payload
    logic signed [31:0]   ctl_reg;
    logic signed [SW-1:0] step_reg, step_next;
    logic [MX+31:0]       m_reg;
    logic [63:0]          lo_reg;
    logic [A-1:0]         idx_reg [4];
    logic signed [15:0]   smp_reg [4];
    logic signed [KW-1:0] k1_reg, k2_reg, k3_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [F+1:0]  rr_reg;
    logic [F-1:0]         r_reg;
    logic [15:0]          out_data_reg;
    logic                 out_past_reg;
    logic [15:0]          mem_q_reg;
    logic [15:0]          sample_mem [2**A];

    logic                 s_accept;
    logic                 out_load;
    logic [A-1:0]         rd_addr;
    logic [2:0]           mode_eff;
    logic [A:0]           len_u;
    logic signed [SW-1:0] len_s, lm1_s, start_s, end_s, endi_s, s_pos, e_pos, pos_w, span_s;
    logic [MX-1:0]        span_mag;
    logic [31:0]          fmag;
    logic signed [32:0]   ctl_x;
    logic                 ctl_pos;
    logic                 ctl_neg;

    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PMW-1:0] mul_p, rnd_p;
    logic [PMW-1:0]        q_sum, q_val;

    logic signed [PW-1:0]  pos_next;
    logic                  past_next;
    logic signed [SW-1:0]  p_t, base_t, ip_t;
    logic signed [IW-1:0]  ip_i, len_i, lm1_i;
    logic signed [IW-1:0]  ix [4];
    logic [2:0]            n_calc;
    interp_t               it_calc;
    logic [F:0]            lw;
    logic signed [AW-1:0]  val_s;
    logic [15:0]           val_sat;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_past_reg;
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;

    // register read
    always_comb
    begin
        prdata = '0;
        case (paddr[4:2])
            isp_pkg::REG_PLAY_MODE:   prdata = 32'(mode_reg);
            isp_pkg::REG_LENGTH:      prdata = 32'(length_reg);
            isp_pkg::REG_START:       prdata = 32'(start_reg);
            isp_pkg::REG_END:         prdata = 32'(end_reg);
            isp_pkg::REG_RATE_RATIO:  prdata = 32'(ratio_reg);
            isp_pkg::REG_INV_SYSRATE: prdata = isr_reg;
            default:                  prdata = '0;
        endcase
    end

    // derived configuration
    always_comb
    begin
        mode_eff = (mode_reg > isp_pkg::MODE_REGION_CUB) ? isp_pkg::MODE_LOOP : mode_reg;
        if (length_reg == '0)
            len_u = (A+1)'(1);
        else if (32'(length_reg) > LEN_CAP)
            len_u = (A+1)'(LEN_CAP);
        else
            len_u = (A+1)'(length_reg);
        len_s   = SW'(len_u);
        lm1_s   = len_s - SW'(1);
        start_s = SW'(start_reg);
        end_s   = SW'(end_reg);
        endi_s  = (end_s > lm1_s) ? lm1_s : end_s;
        s_pos   = start_s <<< F;
        e_pos   = endi_s <<< F;
        span_s  = endi_s - start_s;
        span_mag = span_s[SW-1] ? MX'(-span_s) : MX'(span_s);
        ctl_x   = 33'(ctl_reg);
        fmag    = ctl_x[32] ? 32'(-ctl_x) : 32'(ctl_x);
        ctl_pos = (ctl_reg > 0);
        ctl_neg = ctl_reg[31];
        pos_w   = SW'(pos_reg);
        len_i   = IW'(len_s);
        lm1_i   = IW'(lm1_s);
        ip_i    = IW'(pos_w >>> F);
        lw      = {1'b1, {F{1'b0}}} - {1'b0, r_reg};
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_INC:
            begin
                if (mode_eff >= isp_pkg::MODE_REGION_LIN)
                begin
                    mul_a = MW'(span_mag);
                    mul_b = MW'(fmag);
                end
                else
                begin
                    mul_a = MW'(ctl_reg);
                    mul_b = MW'(ratio_reg);
                end
            end
            S_LO:
            begin
                mul_a = MW'(m_reg[31:0]);
                mul_b = MW'(isr_reg);
            end
            S_HI:
            begin
                mul_a = MW'(m_reg[MX+31:32]);
                mul_b = MW'(isr_reg);
            end
            S_L1:
            begin
                mul_a = MW'(lw);
                mul_b = MW'(smp_reg[0]);
            end
            S_L2:
            begin
                mul_a = MW'(r_reg);
                mul_b = MW'(smp_reg[1]);
            end
            S_H1:
            begin
                mul_a = MW'(k3_reg);
                mul_b = MW'(rr_reg);
            end
            S_H2, S_H3:
            begin
                mul_a = MW'(acc_reg);
                mul_b = MW'(rr_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign rnd_p = (mul_p + (PMW'(1) <<< (F - 1))) >>> F;
    assign q_sum = ($unsigned(mul_p) << 8) + PMW'(lo_reg >> 24);
    assign q_val = q_sum >> (24 - F);

    // step and accumulator next values
    always_comb
    begin
        step_next = step_reg;
        acc_next  = acc_reg;
        unique case (state_reg)
            S_INC:  step_next = SW'(mul_p >>> (32 - F));
            // step direction follows both the rate sign and the region span sign
            S_HI:   step_next = (ctl_pos != span_s[SW-1]) ? SW'(q_val) : -SW'(q_val);
            S_L1:   acc_next = AW'(mul_p);
            S_L2:   acc_next = acc_reg + AW'(mul_p);
            S_H1:   acc_next = AW'(rnd_p) + AW'(k2_reg);
            S_H2:   acc_next = AW'(rnd_p) + AW'(k1_reg);
            S_H3:   acc_next = AW'(mul_p) + (AW'(smp_reg[1]) <<< (F + 1));
            default:
            begin
                step_next = step_reg;
                acc_next  = acc_reg;
            end
        endcase
    end

    // position update
    always_comb
    begin
        past_next = 1'b0;
        base_t    = pos_w;
        p_t       = pos_w;
        ip_t      = '0;
        unique case (mode_eff)
            isp_pkg::MODE_LOOP, isp_pkg::MODE_ONCE:
            begin
                p_t  = clamp_pos(pos_w + ONE_S);
                ip_t = p_t >>> F;
                if (ip_t >= len_s)
                begin
                    if (mode_eff == isp_pkg::MODE_LOOP)
                        p_t = '0;
                    else
                        past_next = 1'b1;
                end
            end
            isp_pkg::MODE_LOOP_SPEED, isp_pkg::MODE_ONCE_SPEED:
            begin
                p_t = clamp_pos(pos_w + step_reg);
                if (mode_eff == isp_pkg::MODE_ONCE_SPEED && p_t < 0)
                    p_t = '0;
                ip_t = p_t >>> F;
                if (mode_eff == isp_pkg::MODE_ONCE_SPEED)
                    past_next = (ip_t >= len_s);
                else if (!ctl_neg)
                begin
                    if (ip_t >= lm1_s)
                        p_t = ONE_S;
                end
                else if (ip_t < 0)
                    p_t = len_s <<< F;
            end
            default:
            begin
                if (ctl_pos)
                begin
                    if (base_t < s_pos)
                        base_t = s_pos;
                    if (base_t >= e_pos)
                        base_t = s_pos;
                end
                else if (base_t <= s_pos)
                    base_t = e_pos;
                p_t = clamp_pos(base_t + step_reg);
            end
        endcase
        pos_next = PW'(p_t);
    end

    // neighbor indexes for the interpolation
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            ix[k] = ip_i;
        n_calc  = 3'd1;
        it_calc = IT_DIRECT;
        unique case (mode_eff)
            isp_pkg::MODE_LOOP, isp_pkg::MODE_ONCE:
            begin
                n_calc  = 3'd1;
                it_calc = IT_DIRECT;
            end
            isp_pkg::MODE_LOOP_SPEED, isp_pkg::MODE_ONCE_SPEED:
            begin
                n_calc  = 3'd2;
                it_calc = IT_LERP;
                if (mode_eff == isp_pkg::MODE_ONCE_SPEED || !ctl_neg)
                begin
                    ix[0] = ip_i + IW'(1);
                    ix[1] = ip_i + IW'(2);
                end
                else
                begin
                    ix[0] = ip_i - IW'(1);
                    ix[1] = ip_i - IW'(2);
                end
            end
            isp_pkg::MODE_REGION_LIN:
            begin
                n_calc  = 3'd2;
                it_calc = IT_LERP;
                if (ctl_pos)
                begin
                    ix[0] = (ip_i + IW'(1) < len_i) ? ip_i + IW'(1) : ip_i - IW'(1);
                    ix[1] = ip_i + IW'(2);
                end
                else
                begin
                    ix[0] = ip_i - IW'(1);
                    ix[1] = ip_i - IW'(2);
                end
            end
            default:
            begin
                n_calc  = 3'd4;
                it_calc = IT_HERM;
                ix[1]   = ip_i;
                if (ctl_pos)
                begin
                    ix[0] = (pos_w > 0) ? ip_i - IW'(1) : '0;
                    ix[2] = (pos_w < ((endi_s - SW'(2)) <<< F)) ? ip_i + IW'(1) : '0;
                    ix[3] = (pos_w < ((endi_s - SW'(3)) <<< F)) ? ip_i + IW'(2) : '0;
                end
                else
                begin
                    ix[0] = (pos_w > s_pos && pos_w < ((endi_s - SW'(1)) <<< F)) ?
                            ip_i + IW'(1) : '0;
                    ix[2] = (pos_w > s_pos) ? ip_i - IW'(1) : '0;
                    ix[3] = (pos_w > s_pos + ONE_S) ? ip_i - IW'(2) : '0;
                end
            end
        endcase
    end

    // final rounding and saturation
    always_comb
    begin
        unique case (itype_reg)
            IT_LERP:   val_s = (acc_reg + (AW'(1) <<< (F - 1))) >>> F;
            IT_HERM:   val_s = (acc_reg + (AW'(1) <<< F)) >>> (F + 1);
            IT_DIRECT: val_s = AW'(smp_reg[0]);
            default:   val_s = '0;
        endcase
        if (val_s > AW'(isp_pkg::SAMPLE_MAX))
            val_sat = 16'(isp_pkg::SAMPLE_MAX);
        else if (val_s < AW'(isp_pkg::SAMPLE_MIN))
            val_sat = 16'(isp_pkg::SAMPLE_MIN);
        else
            val_sat = val_s[15:0];
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);
    assign rd_addr  = idx_reg[rd_cnt_reg[1:0]];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_accept && s_tuser == isp_pkg::KIND_TICK)
                begin
                    if (mode_eff <= isp_pkg::MODE_ONCE)
                        state_next = S_POS;
                    else
                        state_next = S_INC;
                end
            S_INC:
                state_next = (mode_eff >= isp_pkg::MODE_REGION_LIN) ? S_LO : S_POS;
            S_LO:   state_next = S_HI;
            S_HI:   state_next = S_POS;
            S_POS:  state_next = past_next ? S_OUT : S_IDX;
            S_IDX:  state_next = S_RD;
            S_RD:
                if (rd_cnt_reg == n_reg)
                begin
                    unique case (itype_reg)
                        IT_LERP: state_next = S_L1;
                        IT_HERM: state_next = S_COEF;
                        default: state_next = S_OUT;
                    endcase
                end
            S_COEF: state_next = S_H1;
            S_L1:   state_next = S_L2;
            S_L2:   state_next = S_OUT;
            S_H1:   state_next = S_H2;
            S_H2:   state_next = S_H3;
            S_H3:   state_next = S_OUT;
            S_OUT:  state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            itype_reg     <= IT_DIRECT;
            rd_cnt_reg    <= '0;
            n_reg         <= 3'd1;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            past_reg      <= 1'b0;
            mode_reg      <= isp_pkg::MODE_RST;
            length_reg    <= isp_pkg::LENGTH_RST;
            start_reg     <= isp_pkg::START_RST;
            end_reg       <= isp_pkg::END_RST;
            ratio_reg     <= isp_pkg::RATIO_RST;
            isr_reg       <= isp_pkg::ISR_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (paddr[4:2])
                    isp_pkg::REG_PLAY_MODE:   mode_reg   <= pwdata[isp_pkg::MODE_W-1:0];
                    isp_pkg::REG_LENGTH:      length_reg <= pwdata[isp_pkg::LENGTH_W-1:0];
                    isp_pkg::REG_START:       start_reg  <= pwdata[isp_pkg::REGION_W-1:0];
                    isp_pkg::REG_END:         end_reg    <= pwdata[isp_pkg::REGION_W-1:0];
                    isp_pkg::REG_RATE_RATIO:  ratio_reg  <= pwdata[isp_pkg::RATIO_W-1:0];
                    isp_pkg::REG_INV_SYSRATE: isr_reg    <= pwdata;
                    default:                  ;
                endcase
            end
            if (s_accept && s_tuser == isp_pkg::KIND_TRIGGER)
                pos_reg <= '0;
            if (state_reg == S_POS)
            begin
                pos_reg  <= pos_next;
                past_reg <= past_next;
                if (past_next)
                    itype_reg <= IT_ZERO;
            end
            if (state_reg == S_IDX)
            begin
                itype_reg  <= it_calc;
                n_reg      <= n_calc;
                rd_cnt_reg <= '0;
            end
            if (state_reg == S_RD)
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
            // hold the result until the sink takes it
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
            ctl_reg <= s_tdata[63:32];
        step_reg <= step_next;
        acc_reg  <= acc_next;
        if (state_reg == S_INC)
            m_reg <= mul_p[MX+31:0];
        if (state_reg == S_LO)
            lo_reg <= mul_p[63:0];
        if (state_reg == S_IDX)
        begin
            for (int k = 0; k < 4; k++)
                idx_reg[k] <= clamp_idx(ix[k], lm1_i);
            r_reg  <= pos_reg[F-1:0];
            rr_reg <= ctl_pos ? $signed({2'b00, pos_reg[F-1:0]})
                              : -$signed({2'b00, pos_reg[F-1:0]});
        end
        if (state_reg == S_RD && rd_cnt_reg != 3'd0)
            smp_reg[2'(rd_cnt_reg - 3'd1)] <= mem_q_reg;
        if (state_reg == S_COEF)
        begin
            // doubled Hermite coefficients from neighbors a, b, c, d
            k1_reg <= KW'(smp_reg[2]) - KW'(smp_reg[0]);
            k2_reg <= (KW'(smp_reg[0]) <<< 1) - ((KW'(smp_reg[1]) <<< 2) + KW'(smp_reg[1]))
                      + (KW'(smp_reg[2]) <<< 2) - KW'(smp_reg[3]);
            k3_reg <= (KW'(smp_reg[3]) - KW'(smp_reg[0]))
                      + ((KW'(smp_reg[1]) - KW'(smp_reg[2])) <<< 1)
                      + (KW'(smp_reg[1]) - KW'(smp_reg[2]));
        end
        if (out_load)
        begin
            out_data_reg <= val_sat;
            out_past_reg <= past_reg;
        end
    end

    // sample memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (s_accept && s_tuser == isp_pkg::KIND_WRITE)
            sample_mem[A'(s_tdata[15:0])] <= s_tdata[31:16];
        mem_q_reg <= sample_mem[rd_addr];
    end

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !(s_accept && s_tuser == isp_pkg::KIND_TRIGGER))
        |=> $stable(pos_reg))
        else $error("play position moved outside the update step");

    a_past_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("past-end result carries a nonzero sample");

    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (rd_cnt_reg <= n_reg && $onehot(n_reg)))
        else $error("neighbor fetch count out of range");

    a_pos_floor: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(pos_reg) >= -POS_MAX)
        else $error("play position below negative limit");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && state_reg == S_IDLE))
        else $error("finished tick did not present its result");

endmodule

[bench/isp_voice_checker.sv]
// isp_voice_checker: watches the stream and APB channels of the sample player, predicts
// each tick result from its own copy of the voice state and compares it with the output.
// Depends on isp_pkg.
`timescale 1ns / 1ps

module isp_voice_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam longint ONE     = 64'sd1 <<< 16;
    localparam longint POS_MAX = (64'sd1 <<< 32) - 1;

    typedef struct packed {
        logic signed [15:0] smp;
        logic               past;
    } voice_out_t;

    voice_out_t expected_q[$];

    logic signed [15:0]           samples [0:65535];
    longint                       position;
    logic [isp_pkg::MODE_W-1:0]   mode_r;
    logic [isp_pkg::LENGTH_W-1:0] length_r;
    logic [isp_pkg::REGION_W-1:0] start_r;
    logic [isp_pkg::REGION_W-1:0] end_r;
    logic [isp_pkg::RATIO_W-1:0]  ratio_r;
    logic [isp_pkg::ISR_W-1:0]    isr_r;

    function automatic longint clamp_position(longint p);
        if (p > POS_MAX) return POS_MAX;
        if (p < -POS_MAX) return -POS_MAX;
        return p;
    endfunction

    function automatic longint fetch(longint i, longint l);
        if (i < 0) i = 0;
        if (i > l - 1) i = l - 1;
        return longint'(samples[i[15:0]]);
    endfunction

    function automatic longint blend(longint x, longint y, longint r);
        return ((ONE - r) * x + r * y + (ONE >>> 1)) >>> 16;
    endfunction

    function automatic longint hermite4(longint a, longint b, longint c, longint d,
                                        longint rr);
        longint k1, k2, k3, u;
        k1 = c - a;
        k2 = 2 * a - 5 * b + 4 * c - d;
        k3 = (d - a) + 3 * (b - c);
        u = ((k3 * rr + (ONE >>> 1)) >>> 16) + k2;
        u = ((u * rr + (ONE >>> 1)) >>> 16) + k1;
        return (u * rr + 2 * b * ONE + ONE) >>> 17;
    endfunction

    function automatic longint region_increment(longint span, longint unsigned fmag);
        longint unsigned m, hi, lo, q;
        m  = longint'(span < 0 ? -span : span) * fmag;
        hi = (m >> 32) * longint'(isr_r);
        lo = (m & 64'hffff_ffff) * longint'(isr_r);
        q  = ((hi << 8) + (lo >> 24)) >> 8;
        return span < 0 ? -longint'(q) : longint'(q);
    endfunction

    // Advance the play position by one tick and return the sample it produces.
    function automatic voice_out_t play_tick(longint ctl);
        voice_out_t res;
        longint l, pos, ip, r, v, inc, endi, s_pos, e_pos, span;
        logic [isp_pkg::MODE_W-1:0] md;
        logic past;
        l = longint'(length_r);
        if (l < 1) l = 1;
        if (l > 65536) l = 65536;
        md = (mode_r > isp_pkg::MODE_REGION_CUB) ? isp_pkg::MODE_LOOP : mode_r;
        pos = position;
        v = 0;
        past = 1'b0;
        if (md == isp_pkg::MODE_LOOP || md == isp_pkg::MODE_ONCE) begin
            pos = clamp_position(pos + ONE);
            ip = pos >>> 16;
            if (md == isp_pkg::MODE_LOOP) begin
                if (ip >= l) begin
                    pos = 0;
                    ip = 0;
                end
                v = fetch(ip, l);
            end else if (ip < l) begin
                v = fetch(ip, l);
            end else begin
                past = 1'b1;
            end
        end else if (md == isp_pkg::MODE_LOOP_SPEED || md == isp_pkg::MODE_ONCE_SPEED) begin
            inc = (ctl * longint'(ratio_r)) >>> 16;
            pos = clamp_position(pos + inc);
            if (md == isp_pkg::MODE_ONCE_SPEED && pos < 0) pos = 0;
            ip = pos >>> 16;
            if (md == isp_pkg::MODE_ONCE_SPEED) begin
                if (ip < l) v = blend(fetch(ip + 1, l), fetch(ip + 2, l), pos & (ONE - 1));
                else past = 1'b1;
            end else if (ctl >= 0) begin
                if (ip >= l - 1) pos = ONE;
                ip = pos >>> 16;
                v = blend(fetch(ip + 1, l), fetch(ip + 2, l), pos & (ONE - 1));
            end else begin
                if (ip < 0) pos = l * ONE;
                ip = pos >>> 16;
                v = blend(fetch(ip - 1, l), fetch(ip - 2, l), pos & (ONE - 1));
            end
        end else begin
            endi = longint'(end_r);
            if (endi > l - 1) endi = l - 1;
            s_pos = longint'(start_r) * ONE;
            e_pos = endi * ONE;
            span = endi - longint'(start_r);
            if (ctl > 0) begin
                if (pos < s_pos) pos = s_pos;
                if (pos >= e_pos) pos = s_pos;
                pos = clamp_position(pos + region_increment(span, ctl));
            end else begin
                if (pos <= s_pos) pos = e_pos;
                pos = clamp_position(pos - region_increment(span, -ctl));
            end
            ip = pos >>> 16;
            r = pos & (ONE - 1);
            if (md == isp_pkg::MODE_REGION_LIN) begin
                if (ctl > 0)
                    v = blend(fetch(ip + 1 < l ? ip + 1 : ip - 1, l), fetch(ip + 2, l), r);
                else
                    v = blend(fetch(ip - 1, l), fetch(ip - 2, l), r);
            end else if (ctl > 0) begin
                v = hermite4(pos > 0 ? fetch(ip - 1, l) : fetch(0, l), fetch(ip, l),
                             pos < (endi - 2) * ONE ? fetch(ip + 1, l) : fetch(0, l),
                             pos < (endi - 3) * ONE ? fetch(ip + 2, l) : fetch(0, l), r);
            end else begin
                v = hermite4((pos > s_pos && pos < (endi - 1) * ONE) ? fetch(ip + 1, l)
                                                                    : fetch(0, l),
                             fetch(ip, l),
                             pos > s_pos ? fetch(ip - 1, l) : fetch(0, l),
                             pos > s_pos + ONE ? fetch(ip - 2, l) : fetch(0, l), -r);
            end
        end
        position = pos;
        if (v > isp_pkg::SAMPLE_MAX) v = isp_pkg::SAMPLE_MAX;
        if (v < isp_pkg::SAMPLE_MIN) v = isp_pkg::SAMPLE_MIN;
        res.smp = v[15:0];
        res.past = past;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        voice_out_t exp_v;
        logic signed [31:0] ctl;
        int errs;
        if (!rst_n) begin
            position = 0;
            mode_r     <= isp_pkg::MODE_RST;
            length_r   <= isp_pkg::LENGTH_RST;
            start_r    <= isp_pkg::START_RST;
            end_r      <= isp_pkg::END_RST;
            ratio_r    <= isp_pkg::RATIO_RST;
            isr_r      <= isp_pkg::ISR_RST;
            fail_count <= 0;
            pending    <= 0;
            expected_q.delete();
        end else begin
            errs = 0;
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    isp_pkg::REG_PLAY_MODE:   mode_r   <= pwdata[isp_pkg::MODE_W-1:0];
                    isp_pkg::REG_LENGTH:      length_r <= pwdata[isp_pkg::LENGTH_W-1:0];
                    isp_pkg::REG_START:       start_r  <= pwdata[isp_pkg::REGION_W-1:0];
                    isp_pkg::REG_END:         end_r    <= pwdata[isp_pkg::REGION_W-1:0];
                    isp_pkg::REG_RATE_RATIO:  ratio_r  <= pwdata[isp_pkg::RATIO_W-1:0];
                    isp_pkg::REG_INV_SYSRATE: isr_r    <= pwdata[isp_pkg::ISR_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transfer: sample_out %0d past_end %0d",
                           $signed(m_tdata), m_tuser[0]);
                    errs++;
                end else begin
                    exp_v = expected_q.pop_front();
                    if (exp_v.smp !== m_tdata) begin
                        $error("sample_out expected %0d actual %0d", exp_v.smp,
                               $signed(m_tdata));
                        errs++;
                    end
                    if (exp_v.past !== m_tuser[0]) begin
                        $error("past_end expected %0d actual %0d", exp_v.past, m_tuser[0]);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            if (s_tvalid && s_tready) begin
                ctl = s_tdata[63:32];
                if (s_tuser == isp_pkg::KIND_WRITE)
                    samples[s_tdata[15:0]] = s_tdata[31:16];
                else if (s_tuser == isp_pkg::KIND_TRIGGER)
                    position = 0;
                else if (s_tuser == isp_pkg::KIND_TICK)
                    expected_q.push_back(play_tick(longint'(ctl)));
            end
            pending <= expected_q.size();
        end
    end

endmodule

[bench/tb_interpolating_sample_player.sv]
// tb_interpolating_sample_player: drives sample writes, triggers and ticks with random
// gaps and back-pressure across many register settings; isp_voice_checker judges results.
// Depends on isp_pkg, interpolating_sample_player and isp_voice_checker.
`timescale 1ns / 1ps

module tb_interpolating_sample_player;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int  fail_count;
    int  pending;
    int  burst_left = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  written [0:65535];

    interpolating_sample_player DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    isp_voice_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        #10ms;
        $display("FAIL interpolating_sample_player");
        $finish;
    end

    // Result side: short stall pattern, with a long hold-off every so often.
    initial
    begin
        int next_hold;
        next_hold = 3000;
        @(posedge rst_n);
        forever begin
            if (cycle_count >= next_hold) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                next_hold = next_hold + 25000;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    end

    task automatic send(input logic [1:0] kind, input logic [15:0] addr,
                        input logic [15:0] data, input logic [31:0] ctl);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {ctl, data, addr};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        if (kind == isp_pkg::KIND_WRITE) written[addr] = 1'b1;
        if (kind != isp_pkg::KIND_RESERVED) items_sent++;
    endtask

    // Hold input and wait until every expected result is out and the block has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] pick_rate(input logic [2:0] mode);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'd0;
            default:
                if (mode == isp_pkg::MODE_LOOP_SPEED || mode == isp_pkg::MODE_ONCE_SPEED)
                    return 32'($urandom_range(0, 6 << 16)) - 32'(3 << 16);
                else
                    return 32'($urandom_range(0, 1000 << 16)) - 32'(500 << 16);
        endcase
    endfunction

    task automatic run_phase(input logic [2:0] mode, input logic [16:0] len,
                             input logic [15:0] start, input logic [15:0] stop,
                             input logic [23:0] ratio, input logic [31:0] isr,
                             input int n, input int fill_cap);
        int l, fill, sel;
        logic [15:0] a;
        drain();
        reg_write(isp_pkg::REG_PLAY_MODE, 32'(mode));
        reg_write(isp_pkg::REG_LENGTH, 32'(len));
        reg_write(isp_pkg::REG_START, 32'(start));
        reg_write(isp_pkg::REG_END, 32'(stop));
        reg_write(isp_pkg::REG_RATE_RATIO, 32'(ratio));
        reg_write(isp_pkg::REG_INV_SYSRATE, isr);
        l = (len == 0) ? 1 : int'(len);
        fill = (l < fill_cap) ? l : fill_cap;
        // every entry that the read clamp can reach must hold a written sample
        for (int i = 0; i < fill; i++)
            if (!written[i]) send(isp_pkg::KIND_WRITE, i[15:0], 16'($urandom), $urandom);
        send(isp_pkg::KIND_TRIGGER, 16'($urandom), 16'($urandom), $urandom);
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                send(isp_pkg::KIND_TICK, 16'($urandom), 16'($urandom), pick_rate(mode));
            end else if (sel < 76) begin
                send(isp_pkg::KIND_TRIGGER, 16'($urandom), 16'($urandom), $urandom);
            end else if (sel < 96) begin
                a = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, fill - 1))
                                                : 16'($urandom);
                send(isp_pkg::KIND_WRITE, a, 16'($urandom), $urandom);
            end else begin
                send(isp_pkg::KIND_RESERVED, 16'($urandom), 16'($urandom), $urandom);
            end
        end
    endtask

    initial
    begin
        logic [2:0]  mode;
        logic [16:0] len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: sample extremes, both address extremes, every kind including kind 3.
        reg_write(isp_pkg::REG_LENGTH, 32'd8);
        send(isp_pkg::KIND_WRITE, 16'd0, 16'h8000, 32'h0);
        send(isp_pkg::KIND_WRITE, 16'd1, 16'h7fff, 32'h0);
        send(isp_pkg::KIND_WRITE, 16'd2, 16'h0000, 32'h0);
        send(isp_pkg::KIND_WRITE, 16'd3, 16'hffff, 32'h0);
        send(isp_pkg::KIND_WRITE, 16'd4, 16'h7fff, 32'h0);
        send(isp_pkg::KIND_WRITE, 16'd5, 16'h7fff, 32'h0);
        send(isp_pkg::KIND_WRITE, 16'd6, 16'h8000, 32'h0);
        send(isp_pkg::KIND_WRITE, 16'd7, 16'h8000, 32'h0);
        send(isp_pkg::KIND_WRITE, 16'hffff, 16'h1234, 32'hffff_ffff);
        send(isp_pkg::KIND_TRIGGER, 16'h0, 16'h0, 32'h0);
        for (int i = 0; i < 10; i++) send(isp_pkg::KIND_TICK, 16'h0, 16'h0, 32'h0);
        send(isp_pkg::KIND_RESERVED, 16'hffff, 16'hffff, 32'hffff_ffff);

        // Directed settings: each mode, unused modes, length and ratio extremes.
        run_phase(isp_pkg::MODE_ONCE, 17'd8, 16'd0, 16'd7, 24'd65536, 32'd97391, 20, 65536);
        run_phase(isp_pkg::MODE_LOOP_SPEED, 17'd8, 16'd0, 16'd7, 24'hffffff, 32'd97391,
                  20, 65536);
        run_phase(isp_pkg::MODE_ONCE_SPEED, 17'd8, 16'd0, 16'd7, 24'hffffff, 32'd0,
                  20, 65536);
        run_phase(isp_pkg::MODE_ONCE_SPEED, 17'd8, 16'd0, 16'd7, 24'd0, 32'd0, 10, 65536);
        run_phase(isp_pkg::MODE_REGION_LIN, 17'd8, 16'd0, 16'hffff, 24'd0, 32'hffff_ffff,
                  20, 65536);
        run_phase(isp_pkg::MODE_REGION_CUB, 17'd8, 16'd1, 16'd6, 24'd65536, 32'hffff_ffff,
                  20, 65536);
        run_phase(isp_pkg::MODE_SPARE_6, 17'd1, 16'd0, 16'd0, 24'd65536, 32'd97391,
                  10, 65536);
        run_phase(isp_pkg::MODE_SPARE_7, 17'd0, 16'hffff, 16'd0, 24'd65536, 32'd97391,
                  10, 65536);
        // full-length memory: only the first entries are reached from a fresh trigger
        run_phase(isp_pkg::MODE_ONCE, 17'd65536, 16'd0, 16'hffff, 24'd65536, 32'd97391,
                  30, 64);
        run_phase(isp_pkg::MODE_LOOP, 17'h1ffff, 16'd0, 16'hffff, 24'd65536, 32'd97391,
                  30, 64);

        // Random settings; each phase starts with the block idle.
        while (items_sent < 1250) begin
            mode = 3'($urandom_range(0, 7));
            len = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 1024))
                                              : 17'($urandom_range(1, 64));
            run_phase(mode, len,
                      ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, len + 4)),
                      ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, len + 4)),
                      ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                  : 24'($urandom_range(0, 4 << 16)),
                      ($urandom_range(0, 7) == 0) ? $urandom
                                                  : $urandom_range(20000, 200000),
                      $urandom_range(40, 120), 65536);
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASS interpolating_sample_player");
        else
            $display("FAIL interpolating_sample_player");
        $finish;
    end

endmodule

[files.f]
hdl/isp_pkg.sv
hdl/interpolating_sample_player.sv
bench/isp_voice_checker.sv
bench/tb_interpolating_sample_player.sv
